### rtl/core/infix_to_postfix_converter_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2P_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2P_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/i2p_pkg.sv
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [SYM_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [SYM_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [SYM_W-1:0] CH_UC_Z   = 8'h5A;

    // Precedence rank: 0 stands for "not an operator", so it sorts below every operator.
    typedef logic [1:0] prec_t;

    localparam prec_t PREC_NONE  = 2'd0;
    localparam prec_t PREC_ADD   = 2'd1;
    localparam prec_t PREC_MUL   = 2'd2;
    localparam prec_t PREC_POWER = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_END,
        ST_LETTER,
        ST_PUSH,
        ST_RPAREN,
        ST_OPER
    } step_t;

    typedef enum logic [1:0] {
        CD_ALWAYS,
        CD_AT_MOST_ONE,
        CD_RP_STOP,
        CD_OP_STOP
    } cond_t;

    typedef enum logic [2:0] {
        AC_NONE,
        AC_EMIT_SYM,
        AC_FLUSH,
        AC_POP_EMIT,
        AC_DISCARD,
        AC_PUSH
    } act_t;

    typedef enum logic [1:0] {
        LS_ONE,
        LS_COND,
        LS_RP,
        LS_OP
    } last_sel_t;

    typedef struct packed {
        cond_t     cond;
        act_t      act_hit;
        step_t     next_hit;
        act_t      act_miss;
        step_t     next_miss;
        last_sel_t last_sel;
        logic      done;
    } uword_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [SYM_W-1:0] data;
    } stack_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             one;
        logic             full;
        logic             top_lp;
        logic             below_lp;
        prec_t            top_prec;
        prec_t            below_prec;
        logic [SYM_W-1:0] top;
    } stack_stat_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             has;
        logic             last;
        logic             done;
        logic             ovf;
    } emit_t;

    function automatic prec_t prec_of(input logic [SYM_W-1:0] ch);
        prec_t p;
        if (ch == CH_PLUS || ch == CH_MINUS) begin
            p = PREC_ADD;
        end else if (ch == CH_STAR || ch == CH_SLASH) begin
            p = PREC_MUL;
        end else if (ch == CH_CARET) begin
            p = PREC_POWER;
        end else begin
            p = PREC_NONE;
        end
        return p;
    endfunction

    function automatic step_t entry_of(input logic action, input logic [SYM_W-1:0] ch);
        step_t s;
        if (action) begin
            s = ST_END;
        end else if ((ch >= CH_LC_A && ch <= CH_LC_Z) || (ch >= CH_UC_A && ch <= CH_UC_Z)) begin
            s = ST_LETTER;
        end else if (ch == CH_LPAREN) begin
            s = ST_PUSH;
        end else if (ch == CH_RPAREN) begin
            s = ST_RPAREN;
        end else begin
            s = ST_OPER;
        end
        return s;
    endfunction

    // Control store: one word per step, with an action and a successor for each outcome
    // of the step's test.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        unique case (s)
            ST_END:    w = '{CD_AT_MOST_ONE, AC_FLUSH, ST_IDLE, AC_FLUSH, ST_END, LS_COND, 1'b1};
            ST_LETTER: w = '{CD_ALWAYS, AC_EMIT_SYM, ST_IDLE, AC_EMIT_SYM, ST_IDLE, LS_ONE, 1'b0};
            ST_PUSH:   w = '{CD_ALWAYS, AC_PUSH, ST_IDLE, AC_PUSH, ST_IDLE, LS_ONE, 1'b0};
            ST_RPAREN: w = '{CD_RP_STOP, AC_DISCARD, ST_IDLE, AC_POP_EMIT, ST_RPAREN, LS_RP, 1'b0};
            ST_OPER:   w = '{CD_OP_STOP, AC_PUSH, ST_IDLE, AC_POP_EMIT, ST_OPER, LS_OP, 1'b0};
            default:   w = '{CD_ALWAYS, AC_NONE, ST_IDLE, AC_NONE, ST_IDLE, LS_ONE, 1'b0};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/i2p_stack.sv
module i2p_stack
    import i2p_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  stack_cmd_t  cmd,
    output stack_stat_t stat
);

    localparam int MEM_DEPTH = 2 ** ADDR_W;

    // The top entry lives in a register; the memory holds the entries beneath it, and
    // below_reg always carries the entry directly under the top.
    logic [SYM_W-1:0]  mem [MEM_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SYM_W-1:0]  top_reg;
    logic [SYM_W-1:0]  top_next;
    logic [SYM_W-1:0]  below_reg;
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  rd_ptr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
            top_next   = cmd.data;
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
            top_next   = below_reg;
        end
    end

    assign wr_en   = cmd.push && (count_reg != '0);
    assign wr_ptr  = count_reg - CNT_W'(1);
    assign rd_ptr  = count_next - CNT_W'(2);
    assign wr_addr = wr_ptr[ADDR_W-1:0];
    assign rd_addr = rd_ptr[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        // A push spills the old top into exactly the slot that becomes the new below entry.
        if (wr_en && wr_addr == rd_addr) begin
            below_reg <= top_reg;
        end else begin
            below_reg <= mem[rd_addr];
        end
    end

    assign stat.count      = count_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.one        = (count_reg == CNT_W'(1));
    assign stat.full       = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.top_lp     = (top_reg == CH_LPAREN);
    assign stat.below_lp   = (below_reg == CH_LPAREN);
    assign stat.top_prec   = prec_of(top_reg);
    assign stat.below_prec = prec_of(below_reg);
    assign stat.top        = top_reg;

endmodule

### rtl/core/i2p_ctrl.sv
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_action,
    input  logic [SYM_W-1:0] in_symbol,
    output logic             in_ready,
    input  logic             out_free,
    input  stack_stat_t      stat,
    output stack_cmd_t       cmd,
    output emit_t            emit,
    output logic             busy
);

    step_t            step_reg;
    step_t            step_next;
    logic [SYM_W-1:0] sym_reg;
    prec_t            prec_reg;
    uword_t           uw;
    logic             hit;
    act_t             act;
    step_t            nxt;
    logic             sel_last;
    logic             advance;
    logic             want_push;
    logic             want_pop;

    always_comb begin
        uw = ucode(step_reg);

        unique case (uw.cond)
            CD_ALWAYS:      hit = 1'b1;
            CD_AT_MOST_ONE: hit = stat.empty || stat.one;
            CD_RP_STOP:     hit = stat.empty || stat.top_lp;
            CD_OP_STOP:     hit = stat.empty || (stat.top_prec <= prec_reg);
            default:        hit = 1'b1;
        endcase

        act = hit ? uw.act_hit : uw.act_miss;
        nxt = hit ? uw.next_hit : uw.next_miss;

        // Looks one entry ahead to tell whether this pop ends the run.
        unique case (uw.last_sel)
            LS_ONE:  sel_last = 1'b1;
            LS_COND: sel_last = hit;
            LS_RP:   sel_last = stat.one || stat.below_lp;
            LS_OP:   sel_last = stat.one || (stat.below_prec <= prec_reg);
            default: sel_last = 1'b1;
        endcase

        emit      = '0;
        want_push = 1'b0;
        want_pop  = 1'b0;
        unique case (act)
            AC_NONE: begin
            end
            AC_EMIT_SYM: begin
                emit.valid  = 1'b1;
                emit.symbol = sym_reg;
                emit.has    = 1'b1;
            end
            AC_FLUSH: begin
                emit.valid = 1'b1;
                if (!stat.empty) begin
                    emit.symbol = stat.top;
                    emit.has    = 1'b1;
                    want_pop    = 1'b1;
                end
            end
            AC_POP_EMIT: begin
                emit.valid  = 1'b1;
                emit.symbol = stat.top;
                emit.has    = 1'b1;
                want_pop    = 1'b1;
            end
            AC_DISCARD: begin
                want_pop = !stat.empty;
            end
            AC_PUSH: begin
                if (stat.full) begin
                    emit.valid = 1'b1;
                    emit.ovf   = 1'b1;
                end else begin
                    want_push = 1'b1;
                end
            end
            default: begin
            end
        endcase
        emit.done = uw.done;
        emit.last = (act == AC_POP_EMIT || act == AC_FLUSH) ? sel_last : 1'b1;

        advance  = !emit.valid || out_free;
        cmd.push = want_push && advance;
        cmd.pop  = want_pop && advance;
        cmd.data = sym_reg;
    end

    assign in_ready = (step_reg == ST_IDLE);
    assign busy     = !in_ready;

    always_comb begin
        step_next = step_reg;
        if (step_reg == ST_IDLE) begin
            if (in_valid) begin
                step_next = entry_of(in_action, in_symbol);
            end
        end else if (advance) begin
            step_next = nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sym_reg  <= in_symbol;
            prec_reg <= prec_of(in_symbol);
        end
    end

endmodule

### rtl/core/infix_to_postfix_converter.sv
// The first result of an item is registered onto m_tvalid by the sequencer's first control step for it.
// Throughput: s_tready stays low while the sequencer runs one control step per cycle for the item,
// and a step that raises a result is held while the output register is full. ')' or an operator
// takes a further step for each operator popped, and a flush takes a step for each stacked entry.
// Reset (aresetn low, synchronous) empties the stack and clears the sequencer and output valid;
// the stack memory itself is not cleared and needs no clearing pass.
module infix_to_postfix_converter
    import i2p_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [SYM_W-1:0] s_tdata,   // [7:0] symbol
    input  logic             s_tuser,   // [0] action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SYM_W-1:0] m_tdata,   // [7:0] out_symbol
    output logic [2:0]       m_tuser,   // [0] has_symbol, [1] expression_done, [2] overflow
    output logic             m_tlast
);

    `include "infix_to_postfix_converter_assert.svh"

    stack_cmd_t       cmd;
    stack_stat_t      stat;
    emit_t            emit;
    logic             busy;
    logic             out_free;
    logic             out_valid_reg;
    logic [SYM_W-1:0] out_symbol_reg;
    logic [2:0]       out_user_reg;
    logic             out_last_reg;

    assign out_free = !out_valid_reg || m_tready;

    i2p_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_symbol (s_tdata),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd),
        .emit      (emit),
        .busy      (busy)
    );

    i2p_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit.valid && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid && out_free) begin
            out_symbol_reg <= emit.symbol;
            out_user_reg   <= {emit.ovf, emit.done, emit.has};
            out_last_reg   <= emit.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_symbol_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    `I2P_ASSERT_IMP(a_idle_no_emit, !busy, !emit.valid, "result raised while sequencer idle")
    `I2P_ASSERT_IMP(a_count_bound, 1'b1, stat.count <= CNT_W'(STACK_DEPTH), "stack count overrun")
    `I2P_ASSERT_IMP(a_ovf_marker, m_tvalid && m_tuser[2], !m_tuser[0] && m_tlast,
                    "overflow result is not a closing marker")
    `I2P_ASSERT_NXT(a_accept_busy, s_tvalid && s_tready, busy, "sequencer idle after a transfer")
    `I2P_ASSERT_IMP(a_no_pop_empty, cmd.pop, !stat.empty, "pop of an empty stack")

endmodule

### tb/sv/i2p_postfix_checker.sv
// Watches both channels of the converter, predicts the postfix output of every
// accepted transfer and compares each result transfer with the oldest prediction.
module i2p_postfix_checker
    import i2p_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [SYM_W-1:0] s_tdata,   // [7:0] symbol
    input  logic             s_tuser,   // [0] action
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [SYM_W-1:0] m_tdata,   // [7:0] out_symbol
    input  logic [2:0]       m_tuser,   // [0] has_symbol, [1] expression_done, [2] overflow
    input  logic             m_tlast,
    output int               fail_count,
    output int               outstanding,
    output int               items_seen,
    output int               results_seen,
    output int               overflow_seen,
    output int               flush_seen
);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             has;
        logic             last;
        logic             done;
        logic             ovf;
    } postfix_t;

    postfix_t         pending_postfix[$];
    logic [SYM_W-1:0] op_stack[STACK_DEPTH];
    int               depth_used;

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        items_seen    = 0;
        results_seen  = 0;
        overflow_seen = 0;
        flush_seen    = 0;
        depth_used    = 0;
    end

    // Binding strength of a stacked or incoming character; anything that is not
    // an arithmetic operator, '(' included, ranks below all of them.
    function automatic int rank_of(input logic [SYM_W-1:0] ch);
        int r;
        if (ch == CH_PLUS || ch == CH_MINUS) begin
            r = 1;
        end else if (ch == CH_STAR || ch == CH_SLASH) begin
            r = 2;
        end else if (ch == CH_CARET) begin
            r = 3;
        end else begin
            r = -1;
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [SYM_W-1:0] ch);
        return (ch >= CH_LC_A && ch <= CH_LC_Z) || (ch >= CH_UC_A && ch <= CH_UC_Z);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    function automatic postfix_t make_result(input logic [SYM_W-1:0] sym, input logic has,
                                             input logic done, input logic ovf);
        postfix_t r;
        r.symbol = sym;
        r.has    = has;
        r.last   = 1'b0;
        r.done   = done;
        r.ovf    = ovf;
        return r;
    endfunction

    task automatic push_or_drop(input logic [SYM_W-1:0] ch, inout postfix_t run_q[$]);
        if (depth_used >= STACK_DEPTH) begin
            run_q.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
        end else begin
            op_stack[depth_used] = ch;
            depth_used++;
        end
    endtask

    task automatic convert_symbol(input logic flush_req, input logic [SYM_W-1:0] ch);
        postfix_t run_q[$];
        int       r;
        if (flush_req) begin
            if (depth_used == 0) begin
                run_q.push_back(make_result('0, 1'b0, 1'b1, 1'b0));
            end
            while (depth_used > 0) begin
                depth_used--;
                run_q.push_back(make_result(op_stack[depth_used], 1'b1, 1'b1, 1'b0));
            end
        end else if (is_letter(ch)) begin
            run_q.push_back(make_result(ch, 1'b1, 1'b0, 1'b0));
        end else if (ch == CH_LPAREN) begin
            push_or_drop(ch, run_q);
        end else if (ch == CH_RPAREN) begin
            while (depth_used > 0 && op_stack[depth_used-1] != CH_LPAREN) begin
                depth_used--;
                run_q.push_back(make_result(op_stack[depth_used], 1'b1, 1'b0, 1'b0));
            end
            if (depth_used > 0) begin
                depth_used--;
            end
        end else begin
            r = rank_of(ch);
            while (depth_used > 0 && rank_of(op_stack[depth_used-1]) > r) begin
                depth_used--;
                run_q.push_back(make_result(op_stack[depth_used], 1'b1, 1'b0, 1'b0));
            end
            push_or_drop(ch, run_q);
        end
        if (run_q.size() > 0) begin
            run_q[run_q.size()-1].last = 1'b1;
        end
        foreach (run_q[i]) begin
            pending_postfix.push_back(run_q[i]);
        end
    endtask

    always @(posedge aclk) begin
        postfix_t got;
        postfix_t want;
        if (!aresetn) begin
            pending_postfix.delete();
            depth_used = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.symbol = m_tdata;
                got.has    = m_tuser[0];
                got.done   = m_tuser[1];
                got.ovf    = m_tuser[2];
                got.last   = m_tlast;
                if (pending_postfix.size() == 0) begin
                    report_mismatch($sformatf("result %0d (symbol %h) arrived with nothing pending",
                                              results_seen, got.symbol));
                end else begin
                    want = pending_postfix.pop_front();
                    if (got.symbol !== want.symbol) begin
                        report_mismatch($sformatf("result %0d: out_symbol %h, expected %h",
                                                  results_seen, got.symbol, want.symbol));
                    end
                    if (got.has !== want.has) begin
                        report_mismatch($sformatf("result %0d: has_symbol %b, expected %b",
                                                  results_seen, got.has, want.has));
                    end
                    if (got.last !== want.last) begin
                        report_mismatch($sformatf("result %0d: tlast %b, expected %b",
                                                  results_seen, got.last, want.last));
                    end
                    if (got.done !== want.done) begin
                        report_mismatch($sformatf("result %0d: expression_done %b, expected %b",
                                                  results_seen, got.done, want.done));
                    end
                    if (got.ovf !== want.ovf) begin
                        report_mismatch($sformatf("result %0d: overflow %b, expected %b",
                                                  results_seen, got.ovf, want.ovf));
                    end
                    if (want.ovf) begin
                        overflow_seen++;
                    end
                    if (want.done && want.last) begin
                        flush_seen++;
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                convert_symbol(s_tuser, s_tdata);
                items_seen++;
            end
        end
        outstanding <= pending_postfix.size();
    end

endmodule

### tb/sv/infix_to_postfix_converter_test.sv
module infix_to_postfix_converter_test;
    import i2p_pkg::*;

    localparam logic ACT_SYMBOL = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [SYM_W-1:0] s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [SYM_W-1:0] m_tdata;
    logic [2:0]       m_tuser;
    logic             m_tlast;

    int   fail_count;
    int   outstanding;
    int   items_seen;
    int   results_seen;
    int   overflow_seen;
    int   flush_seen;
    int   items_sent  = 0;
    int   cycle_count = 0;
    logic calm        = 1'b0;   // when set, neither side idles

    always #4 aclk = ~aclk;

    infix_to_postfix_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    i2p_postfix_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .items_seen    (items_seen),
        .results_seen  (results_seen),
        .overflow_seen (overflow_seen),
        .flush_seen    (flush_seen)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still pending.",
                     cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: a fresh stall is drawn for every result transfer.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Holds tvalid high across back-to-back transfers, so it is only lowered
    // when a gap actually follows.
    task automatic send_item(input logic act, input logic [SYM_W-1:0] ch);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= SYM_W'($urandom_range(0, 255));
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [SYM_W-1:0] pick_letter();
        logic [SYM_W-1:0] ch;
        if ($urandom_range(0, 1) == 0) begin
            ch = CH_LC_A + SYM_W'($urandom_range(0, 25));
        end else begin
            ch = CH_UC_A + SYM_W'($urandom_range(0, 25));
        end
        return ch;
    endfunction

    function automatic logic [SYM_W-1:0] pick_operator();
        logic [SYM_W-1:0] ch;
        case ($urandom_range(0, 4))
            0:       ch = CH_PLUS;
            1:       ch = CH_MINUS;
            2:       ch = CH_STAR;
            3:       ch = CH_SLASH;
            default: ch = CH_CARET;
        endcase
        return ch;
    endfunction

    // A well-formed expression with random letters, operators and nesting.
    task automatic send_expression();
        int operands;
        int open;
        int k;
        operands = $urandom_range(1, 10);
        open     = 0;
        for (k = 0; k < operands; k++) begin
            while (open < 6 && $urandom_range(0, 3) == 0) begin
                send_item(ACT_SYMBOL, CH_LPAREN);
                open++;
            end
            send_item(ACT_SYMBOL, pick_letter());
            while (open > 0 && $urandom_range(0, 2) == 0) begin
                send_item(ACT_SYMBOL, CH_RPAREN);
                open--;
            end
            if (k < operands - 1) begin
                send_item(ACT_SYMBOL, pick_operator());
            end
        end
        while (open > 0) begin
            send_item(ACT_SYMBOL, CH_RPAREN);
            open--;
        end
        send_item(ACT_FLUSH, SYM_W'($urandom_range(0, 255)));
    endtask

    // Fills the stack with one repeated character, which never pops itself,
    // then flushes it; past the stack depth every further push is dropped.
    task automatic send_deep(input logic [SYM_W-1:0] ch, input int reps);
        int k;
        for (k = 0; k < reps; k++) begin
            send_item(ACT_SYMBOL, ch);
        end
        if ($urandom_range(0, 2) == 0) begin
            send_item(ACT_SYMBOL, pick_letter());
        end
        send_item(ACT_FLUSH, SYM_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int pick;
        int k;
        int runs;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_SYMBOL;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Letter range edges, a ')' and a flush on an empty stack, then one
        // expression using every operator, bytes that are neither letters nor
        // known operators, and a ')' with no '(' left to match.
        send_item(ACT_SYMBOL, CH_LC_A);
        send_item(ACT_SYMBOL, CH_UC_Z);
        send_item(ACT_SYMBOL, CH_UC_A);
        send_item(ACT_SYMBOL, CH_LC_Z);
        send_item(ACT_SYMBOL, CH_RPAREN);
        send_item(ACT_FLUSH, 8'h00);
        send_item(ACT_SYMBOL, CH_LPAREN);
        send_item(ACT_SYMBOL, CH_LC_A + 8'd1);
        send_item(ACT_SYMBOL, CH_PLUS);
        send_item(ACT_SYMBOL, CH_LC_A + 8'd2);
        send_item(ACT_SYMBOL, CH_STAR);
        send_item(ACT_SYMBOL, CH_LC_A + 8'd3);
        send_item(ACT_SYMBOL, CH_RPAREN);
        send_item(ACT_SYMBOL, CH_CARET);
        send_item(ACT_SYMBOL, CH_LC_A + 8'd4);
        send_item(ACT_SYMBOL, CH_SLASH);
        send_item(ACT_SYMBOL, CH_LC_A + 8'd5);
        send_item(ACT_SYMBOL, 8'h00);
        send_item(ACT_SYMBOL, CH_MINUS);
        send_item(ACT_SYMBOL, CH_LC_A + 8'd6);
        send_item(ACT_SYMBOL, 8'hFF);
        send_item(ACT_SYMBOL, CH_RPAREN);
        send_item(ACT_FLUSH, 8'hFF);

        // Overflow with '(' and a full-depth flush.
        send_deep(CH_LPAREN, STACK_DEPTH + 1);

        while (items_sent < 300) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                send_expression();
            end else if (pick < 18) begin
                runs = $urandom_range(1, 6);
                for (k = 0; k < runs; k++) begin
                    send_item($urandom_range(0, 7) == 0 ? ACT_FLUSH : ACT_SYMBOL,
                              SYM_W'($urandom_range(0, 255)));
                end
            end else begin
                case ($urandom_range(0, 3))
                    0:       send_deep(CH_LPAREN, $urandom_range(28, 36));
                    1:       send_deep(CH_PLUS, $urandom_range(28, 36));
                    2:       send_deep(CH_STAR, $urandom_range(28, 36));
                    default: send_deep(CH_CARET, $urandom_range(28, 36));
                endcase
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2 * STACK_DEPTH + 16) @(posedge aclk);

        $display("Sent %0d symbols and flushes; %0d postfix results were checked.",
                 items_seen, results_seen);
        $display("Expressions closed: %0d, dropped pushes flagged: %0d.",
                 flush_seen, overflow_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
